@@ hdl/limit_order_book_macros.svh @@
// Assertion macros used by the order book level engine.
`ifndef LIMIT_ORDER_BOOK_MACROS_SVH
`define LIMIT_ORDER_BOOK_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LOB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("order book check failed");

// Next-cycle implication, checked outside reset.
`define LOB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("order book sequencing check failed");

`endif

@@ hdl/lob_pkg.sv @@
// Shared types, constants and bit-search helpers for the order book.
`default_nettype none
package lob_pkg;

    localparam int ORDER_SLOTS_DEF  = 1024;
    localparam int PRICE_LEVELS_DEF = 4096;

    // Fixed field widths
    localparam int QTY_W     = 32;
    localparam int TOTAL_W   = 48;
    localparam int ORDERS_W  = 11;
    localparam int PRICE_W   = 12;
    localparam int ID_W      = 10;
    localparam int PRICE_MAX = 16;   // widest internal price index
    localparam int LEAF_BITS = 64;   // levels per occupancy leaf word
    localparam int LEAF_SEL  = 6;

    localparam logic [TOTAL_W-1:0]  TOTAL_SAT  = '1;
    localparam logic [ORDERS_W-1:0] ORDERS_SAT = '1;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    // Command from the classifier to the level engine
    typedef struct packed {
        logic [1:0]           status;
        logic                 act;      // level update needed
        logic                 remove;   // 1 removes, 0 adds
        logic                 side;
        logic [PRICE_MAX-1:0] price;
        logic [QTY_W-1:0]     qty;
    } t_cmd;

    // One result item
    typedef struct packed {
        logic [1:0]          status;
        logic                bid_valid;
        logic [PRICE_W-1:0]  bid_price;
        logic [TOTAL_W-1:0]  bid_total;
        logic [ORDERS_W-1:0] bid_orders;
        logic                ask_valid;
        logic [PRICE_W-1:0]  ask_price;
        logic [TOTAL_W-1:0]  ask_total;
        logic [ORDERS_W-1:0] ask_orders;
    } t_res;

    // Highest set bit of a leaf word
    function automatic logic [LEAF_SEL-1:0] leaf_msb(input logic [LEAF_BITS-1:0] w);
        logic [LEAF_SEL-1:0] r;
        r = '0;
        for (int i = 0; i < LEAF_BITS; i++) begin
            if (w[i]) r = LEAF_SEL'(i);
        end
        return r;
    endfunction

    // Lowest set bit of a leaf word
    function automatic logic [LEAF_SEL-1:0] leaf_lsb(input logic [LEAF_BITS-1:0] w);
        logic [LEAF_SEL-1:0] r;
        r = '0;
        for (int i = LEAF_BITS - 1; i >= 0; i--) begin
            if (w[i]) r = LEAF_SEL'(i);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hdl/lob_front.sv @@
// Front end: accepts items, reduces indexes, checks the order table, issues commands.
`default_nettype none
module lob_front import lob_pkg::*; #(
    parameter int ORDER_SLOTS  = ORDER_SLOTS_DEF,
    parameter int PRICE_LEVELS = PRICE_LEVELS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_opcode,
    input  wire logic [ID_W-1:0]   i_id,
    input  wire logic              i_side,
    input  wire logic [PRICE_W-1:0] i_price,
    input  wire logic [QTY_W-1:0]  i_quantity,
    output logic                   o_push,
    output t_cmd                   o_cmd,
    input  wire logic              i_full
);

    localparam int IW   = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
    localparam int PW   = (PRICE_LEVELS > 1) ? $clog2(PRICE_LEVELS) : 1;
    localparam int CLRW = $clog2(ORDER_SLOTS + 1);
    localparam int SHW  = 12;              // both indexes are reduced as 12-bit values
    localparam int PDW  = 2 * SHW;         // reciprocal product width
    localparam int RW   = PRICE_MAX + 1;   // remainder width, covers the largest table
    localparam logic [SHW-1:0] P_RECIP = SHW'((1 << SHW) / PRICE_LEVELS);
    localparam logic [SHW-1:0] I_RECIP = SHW'((1 << SHW) / ORDER_SLOTS);

    typedef struct packed {
        logic              live;
        logic              side;
        logic [PW-1:0]     price;
        logic [QTY_W-1:0]  qty;
    } t_slot;

    typedef enum logic [2:0] {F_CLR, F_IDLE, F_MOD, F_RD, F_DEC} t_fstate;

    t_fstate            r_state;
    logic [CLRW-1:0]    r_clr;
    logic [1:0]         r_step;
    logic               r_op;
    logic               r_side;
    logic [QTY_W-1:0]   r_qty;
    logic [SHW-1:0]     r_pr_x;
    logic [SHW-1:0]     r_id_x;
    logic [PDW-1:0]     r_pr_prod;
    logic [PDW-1:0]     r_id_prod;
    logic [RW-1:0]      r_pr_rem;
    logic [RW-1:0]      r_id_rem;
    logic [31:0]        pr_raw;
    logic [31:0]        id_raw;
    t_slot              r_slot [ORDER_SLOTS];
    t_slot              r_slot_rd;
    t_slot              slot_wdata;
    logic [IW-1:0]      slot_waddr;
    logic               slot_we;
    logic [IW-1:0]      id_idx;
    t_cmd               cmd;
    logic               cmd_wr_slot;

    // Remainder estimate from the quotient estimate; off by at most one divisor
    assign pr_raw = 32'(r_pr_x) - 32'(r_pr_prod[PDW-1:SHW]) * 32'(PRICE_LEVELS);
    assign id_raw = 32'(r_id_x) - 32'(r_id_prod[PDW-1:SHW]) * 32'(ORDER_SLOTS);

    assign id_idx = r_id_rem[IW-1:0];

    // Classify against the slot read back from the table
    always_comb begin
        cmd         = '0;
        cmd_wr_slot = 1'b0;
        slot_wdata  = r_slot_rd;
        if (!r_op) begin
            cmd.status  = r_slot_rd.live ? ST_DUP : ST_OK;
            cmd.act     = !r_slot_rd.live;
            cmd.remove  = 1'b0;
            cmd.side    = r_side;
            cmd.price   = PRICE_MAX'(r_pr_rem[PW-1:0]);
            cmd.qty     = r_qty;
            cmd_wr_slot = !r_slot_rd.live;
            slot_wdata  = '{live: 1'b1, side: r_side, price: r_pr_rem[PW-1:0], qty: r_qty};
        end else begin
            cmd.status      = r_slot_rd.live ? ST_OK : ST_UNKNOWN;
            cmd.act         = r_slot_rd.live;
            cmd.remove      = 1'b1;
            cmd.side        = r_slot_rd.side;
            cmd.price       = PRICE_MAX'(r_slot_rd.price);
            cmd.qty         = r_slot_rd.qty;
            cmd_wr_slot     = r_slot_rd.live;
            slot_wdata.live = 1'b0;
        end
    end

    // Slot table write: clearing sweep or update at decision time
    always_comb begin
        slot_we    = 1'b0;
        slot_waddr = id_idx;
        if (r_state == F_CLR) begin
            slot_we    = 1'b1;
            slot_waddr = r_clr[IW-1:0];
        end else if (r_state == F_DEC && !i_full) begin
            slot_we = cmd_wr_slot;
        end
    end

    // Order table memory with registered read
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot[slot_waddr] <= (r_state == F_CLR) ? '0 : slot_wdata;
        end
        r_slot_rd <= r_slot[id_idx];
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_CLR;
            r_clr   <= '0;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                F_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CLRW'(ORDER_SLOTS - 1)) r_state <= F_IDLE;
                end
                F_IDLE: begin
                    if (i_valid) begin
                        r_op    <= i_opcode;
                        r_side  <= i_side;
                        r_qty   <= i_quantity;
                        r_pr_x  <= SHW'(i_price);
                        r_id_x  <= SHW'(i_id);
                        r_step  <= '0;
                        r_state <= F_MOD;
                    end
                end
                // Reduce both indexes: reciprocal multiply, estimate, correct
                F_MOD: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 2'd0) begin
                        r_pr_prod <= PDW'(r_pr_x) * PDW'(P_RECIP);
                        r_id_prod <= PDW'(r_id_x) * PDW'(I_RECIP);
                    end else if (r_step == 2'd1) begin
                        r_pr_rem <= RW'(pr_raw);
                        r_id_rem <= RW'(id_raw);
                    end else begin
                        if (r_pr_rem >= RW'(PRICE_LEVELS))
                            r_pr_rem <= r_pr_rem - RW'(PRICE_LEVELS);
                        if (r_id_rem >= RW'(ORDER_SLOTS))
                            r_id_rem <= r_id_rem - RW'(ORDER_SLOTS);
                        r_state <= F_RD;
                    end
                end
                F_RD: r_state <= F_DEC;
                F_DEC: begin
                    if (!i_full) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == F_IDLE);
    assign o_push  = (r_state == F_DEC) && !i_full;
    assign o_cmd   = cmd;

endmodule
`default_nettype wire

@@ hdl/lob_queue.sv @@
// Two-entry command queue between the classifier and the level engine.
`default_nettype none
module lob_queue import lob_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_cmd,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_cmd,
    input  wire logic i_pop
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

endmodule
`default_nettype wire

@@ hdl/lob_back.sv @@
// Level engine: updates level totals and occupancy, searches best levels, holds the result.
`default_nettype none
`include "limit_order_book_macros.svh"
module lob_back import lob_pkg::*; #(
    parameter int ORDER_SLOTS  = ORDER_SLOTS_DEF,
    parameter int PRICE_LEVELS = PRICE_LEVELS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    output logic      o_res_valid,
    input  wire logic i_res_ready,
    output t_res      o_res
);

    localparam int PW   = (PRICE_LEVELS > 1) ? $clog2(PRICE_LEVELS) : 1;
    localparam int NW   = (PRICE_LEVELS + LEAF_BITS - 1) / LEAF_BITS;
    localparam int WW   = (NW > 1) ? $clog2(NW) : 1;
    localparam int PXW  = WW + LEAF_SEL;
    localparam int CW   = $clog2(ORDER_SLOTS + 1);
    localparam int CLRW = $clog2(PRICE_LEVELS + 1);

    typedef enum logic [3:0] {
        B_CLR, B_IDLE, B_RD, B_UPD, B_BL, B_BP, B_BC, B_AL, B_AP, B_AC, B_OUT
    } t_bstate;

    t_bstate              r_state;
    logic [CLRW-1:0]      r_clr;
    logic [1:0]           r_status;
    logic                 r_remove;
    logic                 r_side;
    logic [PW-1:0]        r_price;
    logic [QTY_W-1:0]     r_qty;

    // Level memories and occupancy leaves, one set per side
    logic [TOTAL_W-1:0]   r_buy_tot  [PRICE_LEVELS];
    logic [CW-1:0]        r_buy_cnt  [PRICE_LEVELS];
    logic [TOTAL_W-1:0]   r_sell_tot [PRICE_LEVELS];
    logic [CW-1:0]        r_sell_cnt [PRICE_LEVELS];
    logic [LEAF_BITS-1:0] r_buy_leaf [NW];
    logic [LEAF_BITS-1:0] r_sell_leaf[NW];
    logic [TOTAL_W-1:0]   r_buy_tot_rd;
    logic [CW-1:0]        r_buy_cnt_rd;
    logic [TOTAL_W-1:0]   r_sell_tot_rd;
    logic [CW-1:0]        r_sell_cnt_rd;
    logic [LEAF_BITS-1:0] r_buy_leaf_rd;
    logic [LEAF_BITS-1:0] r_sell_leaf_rd;
    logic [NW-1:0]        r_top_b;
    logic [NW-1:0]        r_top_s;

    // Search results
    logic [WW-1:0]        r_bw;
    logic [WW-1:0]        r_aw;
    logic                 r_bv;
    logic                 r_av;
    logic [PW-1:0]        r_bp;
    logic [PW-1:0]        r_ap;
    logic [TOTAL_W-1:0]   r_btot;
    logic [TOTAL_W-1:0]   r_atot;
    logic [CW-1:0]        r_bcnt;
    logic [CW-1:0]        r_acnt;

    logic                 r_out_valid;
    t_res                 r_out;

    logic [PXW-1:0]       cmd_ext;
    logic [WW-1:0]        cmd_word;
    logic [LEAF_SEL-1:0]  cmd_bit;
    logic [PXW-1:0]       clr_ext;
    logic [PW-1:0]        lvl_ra;
    logic [WW-1:0]        leaf_ra;
    logic [WW-1:0]        top_msb;
    logic [WW-1:0]        top_lsb;
    logic [PW-1:0]        bid_px;
    logic [PW-1:0]        ask_px;
    logic [TOTAL_W-1:0]   cur_tot;
    logic [CW-1:0]        cur_cnt;
    logic [LEAF_BITS-1:0] cur_leaf;
    logic [TOTAL_W:0]     add_sum;
    logic [TOTAL_W-1:0]   new_tot;
    logic [CW-1:0]        new_cnt;
    logic [LEAF_BITS-1:0] new_leaf;
    logic                 load_out;
    t_res                 res;
    logic [31:0]          bcnt32;
    logic [31:0]          acnt32;
    logic                 chk_bid_on;
    logic                 chk_ask_on;
    logic                 chk_bid_off;
    logic                 bid_fields_zero;

    assign cmd_ext  = PXW'(r_price);
    assign cmd_word = cmd_ext[PXW-1:LEAF_SEL];
    assign cmd_bit  = cmd_ext[LEAF_SEL-1:0];
    assign clr_ext  = PXW'(r_clr[PW-1:0]);
    assign bid_px   = PW'({r_bw, leaf_msb(r_buy_leaf_rd)});
    assign ask_px   = PW'({r_aw, leaf_lsb(r_sell_leaf_rd)});

    // Find highest occupied buy word and lowest occupied sell word
    always_comb begin
        top_msb = '0;
        for (int i = 0; i < NW; i++) begin
            if (r_top_b[i]) top_msb = WW'(i);
        end
        top_lsb = '0;
        for (int i = NW - 1; i >= 0; i--) begin
            if (r_top_s[i]) top_lsb = WW'(i);
        end
    end

    // Select read addresses by step
    always_comb begin
        lvl_ra  = r_price;
        leaf_ra = cmd_word;
        unique case (r_state)
            B_BL:    leaf_ra = top_msb;
            B_AL:    leaf_ra = top_lsb;
            B_BP:    lvl_ra  = bid_px;
            B_AP:    lvl_ra  = ask_px;
            default: begin
                lvl_ra  = r_price;
                leaf_ra = cmd_word;
            end
        endcase
    end

    // Compute the updated level and leaf word
    always_comb begin
        cur_tot  = r_side ? r_sell_tot_rd  : r_buy_tot_rd;
        cur_cnt  = r_side ? r_sell_cnt_rd  : r_buy_cnt_rd;
        cur_leaf = r_side ? r_sell_leaf_rd : r_buy_leaf_rd;
        add_sum  = {1'b0, cur_tot} + (TOTAL_W + 1)'(r_qty);
        if (!r_remove) begin
            new_tot = add_sum[TOTAL_W] ? TOTAL_SAT : add_sum[TOTAL_W-1:0];
            new_cnt = cur_cnt + 1'b1;
        end else begin
            new_tot = (cur_tot > TOTAL_W'(r_qty)) ? (cur_tot - TOTAL_W'(r_qty)) : '0;
            new_cnt = (cur_cnt != '0) ? (cur_cnt - 1'b1) : '0;
            if (new_cnt == '0) new_tot = '0;
        end
        new_leaf          = cur_leaf;
        new_leaf[cmd_bit] = (new_cnt != '0);
    end

    // Level and leaf memories: clearing sweep, update write, registered reads
    always_ff @(posedge i_clk) begin
        if (r_state == B_CLR) begin
            r_buy_tot[r_clr[PW-1:0]]  <= '0;
            r_buy_cnt[r_clr[PW-1:0]]  <= '0;
            r_sell_tot[r_clr[PW-1:0]] <= '0;
            r_sell_cnt[r_clr[PW-1:0]] <= '0;
            r_buy_leaf[clr_ext[PXW-1:LEAF_SEL]]  <= '0;
            r_sell_leaf[clr_ext[PXW-1:LEAF_SEL]] <= '0;
        end else if (r_state == B_UPD) begin
            if (r_side) begin
                r_sell_tot[r_price]   <= new_tot;
                r_sell_cnt[r_price]   <= new_cnt;
                r_sell_leaf[cmd_word] <= new_leaf;
            end else begin
                r_buy_tot[r_price]    <= new_tot;
                r_buy_cnt[r_price]    <= new_cnt;
                r_buy_leaf[cmd_word]  <= new_leaf;
            end
        end
        r_buy_tot_rd   <= r_buy_tot[lvl_ra];
        r_buy_cnt_rd   <= r_buy_cnt[lvl_ra];
        r_sell_tot_rd  <= r_sell_tot[lvl_ra];
        r_sell_cnt_rd  <= r_sell_cnt[lvl_ra];
        r_buy_leaf_rd  <= r_buy_leaf[leaf_ra];
        r_sell_leaf_rd <= r_sell_leaf[leaf_ra];
    end

    // Build the result from the captured best levels
    always_comb begin
        bcnt32         = 32'(r_bcnt);
        acnt32         = 32'(r_acnt);
        res            = '0;
        res.status     = r_status;
        res.bid_valid  = r_bv;
        res.ask_valid  = r_av;
        if (r_bv) begin
            res.bid_price  = PRICE_W'(r_bp);
            res.bid_total  = r_btot;
            res.bid_orders = (bcnt32 > 32'(ORDERS_SAT)) ? ORDERS_SAT : ORDERS_W'(bcnt32);
        end
        if (r_av) begin
            res.ask_price  = PRICE_W'(r_ap);
            res.ask_total  = r_atot;
            res.ask_orders = (acnt32 > 32'(ORDERS_SAT)) ? ORDERS_SAT : ORDERS_W'(acnt32);
        end
    end

    assign load_out = (r_state == B_OUT) && (!r_out_valid || i_res_ready);
    assign o_pop    = (r_state == B_IDLE) && i_valid;

    // Sequencer, occupancy summary and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_CLR;
            r_clr       <= '0;
            r_top_b     <= '0;
            r_top_s     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == CLRW'(PRICE_LEVELS - 1)) r_state <= B_IDLE;
                end
                B_IDLE: begin
                    if (i_valid) begin
                        r_status <= i_cmd.status;
                        r_remove <= i_cmd.remove;
                        r_side   <= i_cmd.side;
                        r_price  <= PW'(i_cmd.price);
                        r_qty    <= i_cmd.qty;
                        r_state  <= i_cmd.act ? B_RD : B_BL;
                    end
                end
                B_RD: r_state <= B_UPD;
                B_UPD: begin
                    if (r_side) r_top_s[cmd_word] <= |new_leaf;
                    else        r_top_b[cmd_word] <= |new_leaf;
                    r_state <= B_BL;
                end
                B_BL: begin
                    r_bw    <= top_msb;
                    r_bv    <= |r_top_b;
                    r_state <= B_BP;
                end
                B_BP: begin
                    r_bp    <= bid_px;
                    r_state <= B_BC;
                end
                B_BC: begin
                    r_btot  <= r_buy_tot_rd;
                    r_bcnt  <= r_buy_cnt_rd;
                    r_state <= B_AL;
                end
                B_AL: begin
                    r_aw    <= top_lsb;
                    r_av    <= |r_top_s;
                    r_state <= B_AP;
                end
                B_AP: begin
                    r_ap    <= ask_px;
                    r_state <= B_AC;
                end
                B_AC: begin
                    r_atot  <= r_sell_tot_rd;
                    r_acnt  <= r_sell_cnt_rd;
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (load_out) r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // Terms for the checks below
    assign chk_bid_on      = r_out_valid && r_out.bid_valid;
    assign chk_ask_on      = r_out_valid && r_out.ask_valid;
    assign chk_bid_off     = r_out_valid && !r_out.bid_valid;
    assign bid_fields_zero = (r_out.bid_price == '0) && (r_out.bid_total == '0)
                             && (r_out.bid_orders == '0);

    // A reported best level always holds at least one order
    `LOB_ASSERT_IMP(a_bid_nonempty, i_clk, i_rst_n, chk_bid_on, r_out.bid_orders != '0)
    `LOB_ASSERT_IMP(a_ask_nonempty, i_clk, i_rst_n, chk_ask_on, r_out.ask_orders != '0)
    // An empty bid side reports zero fields
    `LOB_ASSERT_IMP(a_bid_empty_zero, i_clk, i_rst_n, chk_bid_off, bid_fields_zero)
    // A popped command goes to the update or straight to the search
    `LOB_ASSERT_NXT(a_pop_step, i_clk, i_rst_n, o_pop, r_state == B_RD || r_state == B_BL)

endmodule
`default_nettype wire

@@ hdl/limit_order_book.sv @@
// Top level of the price-level limit order book.
//
// Input stream: tuser carries the opcode (0 add, 1 cancel); tdata carries
// order id, side, price and quantity. Output stream: one result per item
// with status and the best bid and best ask (price, total, order count).
// A transfer happens when tvalid and tready are both high.
// The front end takes one item at a time: index reduction (reciprocal
// multiply, estimate, correct), one order-table read, one decision. The
// level engine handles an accepted item in steps (command pop, level read,
// update, two three-step bitmap searches, output) and a refused one without
// the level read and update; it takes no new command before its result is
// loaded into the output register. After reset the order table is cleared,
// after which input is taken; commands wait in the queue until the level
// memories are cleared.
// A stalled result waits in the output register while the front end and
// the two-entry command queue keep taking items until they fill.
`default_nettype none
module limit_order_book import lob_pkg::*; #(
    parameter int ORDER_SLOTS  = ORDER_SLOTS_DEF,
    parameter int PRICE_LEVELS = PRICE_LEVELS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [55:0]  i_s_tdata,   // id, side, price, quantity, zero pad
    input  wire logic [0:0]   i_s_tuser,   // opcode
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [151:0]      o_m_tdata    // status, bid_valid, bid_price, bid_total,
                                           // bid_orders, ask_valid, ask_price,
                                           // ask_total, ask_orders, zero pad
);

    logic fe_ready;
    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_cmd fe_cmd;
    t_cmd q_cmd;
    t_res res;

    lob_front #(
        .ORDER_SLOTS  (ORDER_SLOTS),
        .PRICE_LEVELS (PRICE_LEVELS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_tvalid),
        .o_ready    (fe_ready),
        .i_opcode   (i_s_tuser[0]),
        .i_id       (i_s_tdata[9:0]),
        .i_side     (i_s_tdata[10]),
        .i_price    (i_s_tdata[22:11]),
        .i_quantity (i_s_tdata[54:23]),
        .o_push     (q_push),
        .o_cmd      (fe_cmd),
        .i_full     (q_full)
    );

    lob_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (fe_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    lob_back #(
        .ORDER_SLOTS  (ORDER_SLOTS),
        .PRICE_LEVELS (PRICE_LEVELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (q_pop),
        .o_res_valid (o_m_tvalid),
        .i_res_ready (i_m_tready),
        .o_res       (res)
    );

    assign o_s_tready = fe_ready;

    // Pack the result, first field lowest
    assign o_m_tdata = {6'd0, res.ask_orders, res.ask_total, res.ask_price, res.ask_valid,
                        res.bid_orders, res.bid_total, res.bid_price, res.bid_valid,
                        res.status};

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the price-level limit order book.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lob_pkg::*;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_CANCEL = 1'b1;
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;
    localparam int   N_IDS     = 1024;
    localparam int   N_LEVELS  = 4096;
    localparam int   CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        op;
        logic [9:0]  id;
        logic        side;
        logic [11:0] price;
        logic [31:0] qty;
    } t_order_cmd;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic [55:0]  s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tready;
    logic         o_s_tready;
    logic         o_m_tvalid;
    logic [151:0] o_m_tdata;

    limit_order_book dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),    // id, side, price, quantity, zero pad
        .i_s_tuser  (s_tuser),    // opcode
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)   // status, bid and ask fields, zero pad
    );

    // Book state mirrored by the predictor
    logic            book_live [N_IDS];
    logic            book_side [N_IDS];
    logic [11:0]     book_price [N_IDS];
    logic [31:0]     book_qty [N_IDS];
    logic [47:0]     level_total [2][N_LEVELS];
    int unsigned     level_count [2][N_LEVELS];

    t_order_cmd      pending_cmds[$];
    t_res            expected_tops[$];
    logic            gen_live [N_IDS];
    int              mismatches = 0;
    longint          cycles = 0;

    // Clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Report side of the book: best level and its totals
    function automatic void best_level(input logic sd, output logic vld,
                                       output logic [11:0] pr, output logic [47:0] tot,
                                       output logic [10:0] cnt);
        int i;
        vld = 1'b0; pr = '0; tot = '0; cnt = '0;
        for (int k = 0; k < N_LEVELS; k++) begin
            i = (sd == SIDE_BUY) ? N_LEVELS - 1 - k : k;
            if (level_count[sd][i] != 0) begin
                vld = 1'b1;
                pr  = 12'(i);
                tot = level_total[sd][i];
                cnt = (level_count[sd][i] > 2047) ? 11'd2047 : 11'(level_count[sd][i]);
                break;
            end
        end
    endfunction

    // Apply one order command and produce the expected top of book
    function automatic t_res apply_order(input t_order_cmd c);
        t_res r;
        logic [48:0] sum;
        logic sd;
        logic [11:0] p;
        r = '0;
        r.status = ST_OK;
        if (c.op == OP_ADD) begin
            if (book_live[c.id]) r.status = ST_DUP;
            else begin
                book_live[c.id]  = 1'b1;
                book_side[c.id]  = c.side;
                book_price[c.id] = c.price;
                book_qty[c.id]   = c.qty;
                sum = {1'b0, level_total[c.side][c.price]} + 49'(c.qty);
                level_total[c.side][c.price] = sum[48] ? TOTAL_SAT : sum[47:0];
                if (level_count[c.side][c.price] != 32'hFFFF_FFFF)
                    level_count[c.side][c.price]++;
            end
        end else begin
            if (!book_live[c.id]) r.status = ST_UNKNOWN;
            else begin
                sd = book_side[c.id];
                p  = book_price[c.id];
                if (level_total[sd][p] > 48'(book_qty[c.id]))
                    level_total[sd][p] = level_total[sd][p] - 48'(book_qty[c.id]);
                else
                    level_total[sd][p] = '0;
                if (level_count[sd][p] != 0) level_count[sd][p]--;
                if (level_count[sd][p] == 0) level_total[sd][p] = '0;
                book_live[c.id] = 1'b0;
            end
        end
        best_level(SIDE_BUY, r.bid_valid, r.bid_price, r.bid_total, r.bid_orders);
        best_level(SIDE_SELL, r.ask_valid, r.ask_price, r.ask_total, r.ask_orders);
        return r;
    endfunction

    // Driver: present queued commands with random gaps, predict on transfer
    int  send_gap;
    int  send_burst;
    always @(posedge i_clk) begin
        t_order_cmd c;
        if (!i_rst_n) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= '0;
            send_gap   <= 0;
            send_burst <= 0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                c.op    = s_tuser[0];
                c.id    = s_tdata[9:0];
                c.side  = s_tdata[10];
                c.price = s_tdata[22:11];
                c.qty   = s_tdata[54:23];
                expected_tops.insert(expected_tops.size(), apply_order(c));
            end
            if (!s_tvalid || o_s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    c = pending_cmds.pop_front();
                    s_tuser  <= c.op;
                    s_tdata  <= {1'b0, c.qty, c.price, c.side, c.id};
                    s_tvalid <= 1'b1;
                    // alternate between gap-free bursts and random idling
                    send_burst <= (send_burst > 0) ? send_burst - 1
                                : (($urandom_range(0, 9) == 0) ? 30 : 0);
                    send_gap <= (send_burst > 0) ? 0 : $urandom_range(0, 9);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random backpressure, compare each result with the oldest expectation
    int  stall_left;
    int  recv_burst;
    always @(posedge i_clk) begin
        t_res got, exp_r;
        if (!i_rst_n) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
            recv_burst <= 0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                got.status     = o_m_tdata[1:0];
                got.bid_valid  = o_m_tdata[2];
                got.bid_price  = o_m_tdata[14:3];
                got.bid_total  = o_m_tdata[62:15];
                got.bid_orders = o_m_tdata[73:63];
                got.ask_valid  = o_m_tdata[74];
                got.ask_price  = o_m_tdata[86:75];
                got.ask_total  = o_m_tdata[134:87];
                got.ask_orders = o_m_tdata[145:135];
                if (expected_tops.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    exp_r = expected_tops.pop_front();
                    if (got.status !== exp_r.status || got.bid_valid !== exp_r.bid_valid ||
                        got.bid_price !== exp_r.bid_price ||
                        got.bid_total !== exp_r.bid_total ||
                        got.bid_orders !== exp_r.bid_orders ||
                        got.ask_valid !== exp_r.ask_valid ||
                        got.ask_price !== exp_r.ask_price ||
                        got.ask_total !== exp_r.ask_total ||
                        got.ask_orders !== exp_r.ask_orders) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("expected st=%0d bid=%0d/%0d/%0d/%0d ask=%0d/%0d/%0d/%0d",
                                exp_r.status, exp_r.bid_valid, exp_r.bid_price, exp_r.bid_total,
                                exp_r.bid_orders, exp_r.ask_valid, exp_r.ask_price,
                                exp_r.ask_total, exp_r.ask_orders);
                            $display("actual   st=%0d bid=%0d/%0d/%0d/%0d ask=%0d/%0d/%0d/%0d",
                                got.status, got.bid_valid, got.bid_price, got.bid_total,
                                got.bid_orders, got.ask_valid, got.ask_price,
                                got.ask_total, got.ask_orders);
                        end
                    end
                end
            end
            // outside a burst, drop ready for a random stall after each transfer
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end else if (o_m_tvalid && m_tready) begin
                recv_burst <= (recv_burst > 0) ? recv_burst - 1
                            : (($urandom_range(0, 9) == 0) ? 30 : 0);
                if (recv_burst > 0) m_tready <= 1'b1;
                else begin
                    stall_left <= $urandom_range(0, 9);
                    m_tready   <= 1'b0;
                end
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Timeout guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Queue one command and track liveness for the generator
    task automatic queue_cmd(input logic op, input int id, input logic sd,
                             input int pr, input logic [31:0] q);
        t_order_cmd c;
        c.op = op; c.id = 10'(id); c.side = sd; c.price = 12'(pr); c.qty = q;
        if (op == OP_ADD) gen_live[id] = 1'b1;
        else gen_live[id] = 1'b0;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    // Pick a live id, or any id if none found quickly
    function automatic int pick_live_id();
        int id;
        for (int t = 0; t < 64; t++) begin
            id = $urandom_range(0, N_IDS - 1);
            if (gen_live[id]) return id;
        end
        return id;
    endfunction

    // Stimulus
    initial begin
        int kind, id, pr;
        logic [31:0] q;
        for (int i = 0; i < N_IDS; i++) begin
            book_live[i] = 1'b0; gen_live[i] = 1'b0;
            book_side[i] = 1'b0; book_price[i] = '0; book_qty[i] = '0;
        end
        for (int i = 0; i < N_LEVELS; i++) begin
            level_total[0][i] = '0; level_total[1][i] = '0;
            level_count[0][i] = 0;  level_count[1][i] = 0;
        end
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty book, extremes, duplicate, unknown, zero quantity
        queue_cmd(OP_CANCEL, 0, SIDE_BUY, 0, 0);
        queue_cmd(OP_ADD, 0, SIDE_BUY, 0, 32'h0);
        queue_cmd(OP_ADD, 1023, SIDE_SELL, 4095, 32'hFFFF_FFFF);
        queue_cmd(OP_ADD, 0, SIDE_SELL, 100, 32'h5);
        queue_cmd(OP_ADD, 1, SIDE_BUY, 4095, 32'hFFFF_FFFF);
        queue_cmd(OP_ADD, 2, SIDE_BUY, 4095, 32'hFFFF_FFFF);
        queue_cmd(OP_ADD, 3, SIDE_SELL, 0, 32'h1234_5678);
        queue_cmd(OP_ADD, 4, SIDE_SELL, 0, 32'h0);
        queue_cmd(OP_CANCEL, 1022, SIDE_SELL, 4095, 32'hFFFF_FFFF);
        queue_cmd(OP_CANCEL, 1, SIDE_BUY, 0, 0);
        queue_cmd(OP_CANCEL, 2, SIDE_BUY, 0, 0);
        queue_cmd(OP_CANCEL, 3, SIDE_SELL, 0, 0);
        queue_cmd(OP_CANCEL, 4, SIDE_SELL, 0, 0);
        queue_cmd(OP_CANCEL, 0, SIDE_BUY, 0, 0);
        queue_cmd(OP_CANCEL, 1023, SIDE_SELL, 0, 0);
        queue_cmd(OP_CANCEL, 1023, SIDE_SELL, 0, 0);

        // Random: mostly adds near a mid price and cancels of live orders
        for (int n = 0; n < 1600; n++) begin
            kind = $urandom_range(0, 99);
            pr = ($urandom_range(0, 4) == 0) ? $urandom_range(0, N_LEVELS - 1)
                                              : $urandom_range(2030, 2066);
            case ($urandom_range(0, 9))
                0:       q = 32'h0;
                1:       q = 32'hFFFF_FFFF;
                default: q = $urandom;
            endcase
            if (kind < 55) begin
                id = $urandom_range(0, N_IDS - 1);
                queue_cmd(OP_ADD, id, 1'($urandom_range(0, 1)), pr, q);
            end else if (kind < 90) begin
                queue_cmd(OP_CANCEL, pick_live_id(), 1'($urandom_range(0, 1)), pr, q);
            end else begin
                // noise: random cancel or an add that may hit a live id
                id = pick_live_id();
                if (kind < 95) begin
                    queue_cmd(OP_ADD, id, 1'($urandom_range(0, 1)), pr, q);
                end else begin
                    queue_cmd(OP_CANCEL, $urandom_range(0, N_IDS - 1),
                              1'($urandom_range(0, 1)), pr, q);
                end
            end
        end

        wait (pending_cmds.size() == 0 && !s_tvalid);
        wait (expected_tops.size() == 0);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && expected_tops.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
